/* rtl/anc_pkg.sv */
package anc_pkg;

    // Status of the shared serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Sequencer state codes
    localparam int unsigned ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] S_BEGIN = 3'd1;
    localparam logic [ST_W-1:0] S_DIV   = 3'd2;
    localparam logic [ST_W-1:0] S_ADDQ  = 3'd3;
    localparam logic [ST_W-1:0] S_END   = 3'd4;
    localparam logic [ST_W-1:0] S_DONE  = 3'd5;

endpackage

/* rtl/anc_div.sv */
module anc_div import anc_pkg::*; #(
    parameter int unsigned DW = 27
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_stat     o_stat,
    output logic [DW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dvs, n_dvs;

    logic [DW:0]   w_rem_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // One restoring step: shift in next dividend bit, subtract when it fits
    assign w_rem_sh = {r_rem, r_quo[DW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (r_busy) begin
            n_rem = w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            n_quo = {r_quo[DW-2:0], w_ge};
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = CW'(DW);
            n_busy = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

endmodule

/* rtl/amicable_number_check_core.sv */
// Sequence: each aliquot sum s(v) tries divisors d = 1 .. floor(sqrt(v)) + 1, each trial
// being one serial division of DW = max(NUM_BITS, SUM_BITS) steps; the whole item takes
// s(n) then s(s(n)), the second pass skipped when s(n) saturates. A new number is taken
// only in the idle state, after the last result is loaded into the output register, so
// items do not overlap: the single shared divider serializes them. Synchronous active-low reset clears the
// sequencer, the divider control and the output valid.
module amicable_number_check_core import anc_pkg::*; #(
    parameter int unsigned NUM_BITS = 24,
    parameter int unsigned SUM_BITS = 27
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [NUM_BITS-1:0] i_number,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SUM_BITS-1:0] o_partner,
    output logic                o_is_amicable,
    output logic                o_is_perfect,
    output logic                o_overflow
);

    localparam int unsigned DW = (NUM_BITS > SUM_BITS) ? NUM_BITS : SUM_BITS;
    localparam int unsigned AW = DW + 3;
    localparam logic [AW-1:0] SUM_MAX = AW'({SUM_BITS{1'b1}});

    logic [ST_W-1:0]     r_state, n_state;
    logic                r_pass, n_pass;
    logic                r_start, n_start;
    logic [DW-1:0]       r_n, n_n;
    logic [DW-1:0]       r_val, n_val;
    logic [DW-1:0]       r_d, n_d;
    logic [DW-1:0]       r_q, n_q;
    logic [AW-1:0]       r_acc, n_acc;
    logic [SUM_BITS-1:0] r_partner, n_partner;
    logic                r_perfect, n_perfect;
    logic                r_amicable, n_amicable;
    logic                r_ovf, n_ovf;
    logic                r_o_valid, n_o_valid;
    logic [SUM_BITS-1:0] r_o_partner, n_o_partner;
    logic                r_o_amic, n_o_amic;
    logic                r_o_perf, n_o_perf;
    logic                r_o_ovf, n_o_ovf;

    t_div_stat           w_div;
    logic [DW-1:0]       w_quo;
    logic [DW-1:0]       w_rem;
    logic [AW-1:0]       w_sum;
    logic                w_sat;

    // Shared trial divider
    anc_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_val),
        .i_divisor  (r_d),
        .o_stat     (w_div),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Aliquot sum = sigma(v) - v
    assign w_sum = r_acc - AW'(r_val);
    assign w_sat = w_sum > SUM_MAX;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_pass      = r_pass;
        n_start     = 1'b0;
        n_n         = r_n;
        n_val       = r_val;
        n_d         = r_d;
        n_q         = r_q;
        n_acc       = r_acc;
        n_partner   = r_partner;
        n_perfect   = r_perfect;
        n_amicable  = r_amicable;
        n_ovf       = r_ovf;
        n_o_valid   = r_o_valid;
        n_o_partner = r_o_partner;
        n_o_amic    = r_o_amic;
        n_o_perf    = r_o_perf;
        n_o_ovf     = r_o_ovf;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_n     = DW'(i_number);
                    n_val   = DW'(i_number);
                    n_pass  = 1'b0;
                    n_state = S_BEGIN;
                end
            end
            S_BEGIN: begin
                // Values below two have an empty sum; preload so acc - v is zero
                if (r_val < DW'(2)) begin
                    n_acc   = AW'(r_val);
                    n_state = S_END;
                end else begin
                    n_acc   = '0;
                    n_d     = DW'(1);
                    n_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    // d*d > v exactly when floor(v/d) < d
                    if (w_quo < r_d) begin
                        n_state = S_END;
                    end else if (w_rem == '0) begin
                        n_acc   = r_acc + AW'(r_d);
                        n_q     = w_quo;
                        n_state = S_ADDQ;
                    end else begin
                        n_d     = r_d + DW'(1);
                        n_start = 1'b1;
                    end
                end
            end
            S_ADDQ: begin
                // Cofactor, unless it is the square root itself
                if (r_q != r_d) begin
                    n_acc = r_acc + AW'(r_q);
                end
                n_d     = r_d + DW'(1);
                n_start = 1'b1;
                n_state = S_DIV;
            end
            S_END: begin
                if (!r_pass) begin
                    n_partner = w_sat ? SUM_MAX[SUM_BITS-1:0] : w_sum[SUM_BITS-1:0];
                    if (w_sat) begin
                        n_ovf      = 1'b1;
                        n_perfect  = 1'b0;
                        n_amicable = 1'b0;
                        n_state    = S_DONE;
                    end else begin
                        n_ovf     = 1'b0;
                        n_perfect = (w_sum == AW'(r_n));
                        n_val     = w_sum[DW-1:0];
                        n_pass    = 1'b1;
                        n_state   = S_BEGIN;
                    end
                end else begin
                    n_ovf      = w_sat;
                    n_amicable = !w_sat && (w_sum == AW'(r_n));
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                // Load the output register once it is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid   = 1'b1;
                    n_o_partner = r_partner;
                    n_o_amic    = r_amicable;
                    n_o_perf    = r_perfect;
                    n_o_ovf     = r_ovf;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pass    <= 1'b0;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pass    <= n_pass;
            r_start   <= n_start;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_val       <= n_val;
        r_d         <= n_d;
        r_q         <= n_q;
        r_acc       <= n_acc;
        r_partner   <= n_partner;
        r_perfect   <= n_perfect;
        r_amicable  <= n_amicable;
        r_ovf       <= n_ovf;
        r_o_partner <= n_o_partner;
        r_o_amic    <= n_o_amic;
        r_o_perf    <= n_o_perf;
        r_o_ovf     <= n_o_ovf;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_o_valid;
    assign o_partner     = r_o_partner;
    assign o_is_amicable = r_o_amic;
    assign o_is_perfect  = r_o_perf;
    assign o_overflow    = r_o_ovf;

    // Divider only finishes while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // A trial never starts with a zero divisor
    a_start_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_d != '0))
        else $error("trial division with zero divisor");

    // A saturated sum never reports a partner pair
    a_ovf_not_amic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> !o_is_amicable)
        else $error("overflow with amicable set");

    // A perfect number is its own partner
    a_perf_amic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_perfect) |-> (o_is_amicable && !o_overflow))
        else $error("perfect without amicable");

endmodule
